### sv/gdsd_pkg.sv
// gdsd_pkg: shared constants, status codes and calendar helpers for the
// Gregorian date minus days block. No dependencies.
`default_nettype none

package gdsd_pkg;

  // Result status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_BAD_YEAR  = 3'd1;
  localparam logic [2:0] STS_BAD_MONTH = 3'd2;
  localparam logic [2:0] STS_BAD_DAY   = 3'd3;
  localparam logic [2:0] STS_UNDERFLOW = 3'd4;

  // Register map (word index)
  localparam logic REG_MIN_YEAR = 1'b0;
  localparam logic REG_MAX_YEAR = 1'b1;

  // Reset values of the year window
  localparam int unsigned MIN_YEAR_RST = 1582;
  localparam int unsigned MAX_YEAR_RST = 2024;

  // Calendar constants
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam int unsigned CENTURY      = 100;
  localparam int unsigned QUAD_CENTURY = 400;

  // Residue unit: restoring reduction modulo 400 over years up to 16 bits
  localparam int unsigned MOD_W     = 17;
  localparam int unsigned MOD_STEPS = 8;
  localparam int unsigned RES_W     = 9;

  // Leap rule from the year modulo 400
  function automatic logic is_leap(input logic [RES_W-1:0] r400);
    logic cent;
    cent = (r400 == RES_W'(CENTURY)) || (r400 == RES_W'(2 * CENTURY)) ||
           (r400 == RES_W'(3 * CENTURY));
    return (r400[1:0] == 2'b00) && !cent;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### sv/gdsd_regs.sv
// gdsd_regs: APB-style configuration registers holding the year window.
// Depends on gdsd_pkg.
`default_nettype none

module gdsd_regs #(
  parameter int YEAR_WIDTH = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output logic      [YEAR_WIDTH-1:0] min_year,
  output logic      [YEAR_WIDTH-1:0] max_year
);
  import gdsd_pkg::*;

  logic [YEAR_WIDTH-1:0] min_year_r, min_year_nxt;
  logic [YEAR_WIDTH-1:0] max_year_r, max_year_nxt;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    min_year_nxt = min_year_r;
    max_year_nxt = max_year_r;
    if (wr_en) begin
      if (paddr[2] == REG_MIN_YEAR) begin
        min_year_nxt = pwdata[YEAR_WIDTH-1:0];
      end else begin
        max_year_nxt = pwdata[YEAR_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= YEAR_WIDTH'(MIN_YEAR_RST);
      max_year_r <= YEAR_WIDTH'(MAX_YEAR_RST);
    end else begin
      min_year_r <= min_year_nxt;
      max_year_r <= max_year_nxt;
    end
  end

  assign prdata   = (paddr[2] == REG_MIN_YEAR) ? 32'(min_year_r) : 32'(max_year_r);
  assign min_year = min_year_r;
  assign max_year = max_year_r;

endmodule

`default_nettype wire

### sv/gdsd_core.sv
// gdsd_core: sequencer and shared datapath; reduces the year modulo 400,
// checks the date, then borrows one month per cycle. Depends on gdsd_pkg.
`default_nettype none

module gdsd_core #(
  parameter int DAYS_WIDTH = 16,
  parameter int YEAR_WIDTH = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [YEAR_WIDTH-1:0] min_year,
  input  wire logic [YEAR_WIDTH-1:0] max_year,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [4:0]            in_day,
  input  wire logic [3:0]            in_month,
  input  wire logic [YEAR_WIDTH-1:0] in_year,
  input  wire logic [DAYS_WIDTH-1:0] in_days_back,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [2:0]            out_status,
  output logic      [4:0]            out_result_day,
  output logic      [3:0]            out_result_month,
  output logic      [YEAR_WIDTH-1:0] out_result_year
);
  import gdsd_pkg::*;

  localparam int D_W = DAYS_WIDTH + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MOD    = 5'b00010,
    S_CHECK  = 5'b00100,
    S_BORROW = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [MOD_W-1:0]      rem_r, rem_nxt;
  logic [4:0]            day_r, day_nxt;
  logic [3:0]            month_r, month_nxt;
  logic [YEAR_WIDTH-1:0] year_r, year_nxt;
  logic [DAYS_WIDTH-1:0] back_r, back_nxt;
  logic [D_W-1:0]        d_r, d_nxt;
  logic [2:0]            status_r, status_nxt;

  logic [MOD_W-1:0]      thr;
  logic [RES_W-1:0]      r400, r400_dec;
  logic                  wrap, d_low, leap_now;
  logic [3:0]            m_prev;

  assign thr      = MOD_W'(QUAD_CENTURY) << step_r;
  assign r400     = rem_r[RES_W-1:0];
  assign r400_dec = (r400 == '0) ? RES_W'(QUAD_CENTURY - 1) : r400 - RES_W'(1);
  assign leap_now = is_leap(r400);
  assign wrap     = (month_r == MONTH_JAN);
  assign m_prev   = wrap ? MONTH_DEC : month_r - 4'd1;
  assign d_low    = d_r[D_W-1] || (d_r == '0);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    rem_nxt    = rem_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    back_nxt   = back_r;
    d_nxt      = d_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          day_nxt   = in_day;
          month_nxt = in_month;
          year_nxt  = in_year;
          back_nxt  = in_days_back;
          rem_nxt   = MOD_W'(in_year);
          step_nxt  = 3'(MOD_STEPS - 1);
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        // one restoring step against 400 shifted left
        if (rem_r >= thr) begin
          rem_nxt = rem_r - thr;
        end
        if (step_r == '0) begin
          state_nxt = S_CHECK;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      S_CHECK: begin
        d_nxt = D_W'(day_r) - D_W'(back_r);
        if (year_r < min_year || year_r > max_year) begin
          status_nxt = STS_BAD_YEAR;
          state_nxt  = S_DONE;
        end else if (month_r == 4'd0 || month_r > MONTH_DEC) begin
          status_nxt = STS_BAD_MONTH;
          state_nxt  = S_DONE;
        end else if (day_r == 5'd0 || day_r > month_len(month_r, leap_now)) begin
          status_nxt = STS_BAD_DAY;
          state_nxt  = S_DONE;
        end else begin
          status_nxt = STS_OK;
          state_nxt  = S_BORROW;
        end
      end
      S_BORROW: begin
        if (!d_low) begin
          state_nxt = S_DONE;
        end else if (wrap && year_r <= min_year) begin
          // stepping into the previous year would leave the window
          status_nxt = STS_UNDERFLOW;
          state_nxt  = S_DONE;
        end else begin
          month_nxt = m_prev;
          if (wrap) begin
            year_nxt = year_r - YEAR_WIDTH'(1);
            rem_nxt  = MOD_W'(r400_dec);
            d_nxt    = d_r + D_W'(month_len(m_prev, is_leap(r400_dec)));
          end else begin
            d_nxt    = d_r + D_W'(month_len(m_prev, leap_now));
          end
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    rem_r    <= rem_nxt;
    day_r    <= day_nxt;
    month_r  <= month_nxt;
    year_r   <= year_nxt;
    back_r   <= back_nxt;
    d_r      <= d_nxt;
    status_r <= status_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = (state_r == S_DONE);
  assign out_status       = status_r;
  assign out_result_day   = (status_r == STS_OK) ? d_r[4:0] : 5'd0;
  assign out_result_month = (status_r == STS_OK) ? month_r : 4'd0;
  assign out_result_year  = (status_r == STS_OK) ? year_r : '0;

endmodule

`default_nettype wire

### sv/gregorian_date_subtract_days.sv
// Per item: capture the input beat, reduce the year mod 400 by restoring steps,
// check the date, then borrow months (one borrow per cycle through the shared
// adder) while the day is not positive; a rejected date skips the borrow.
// One item at a time; in_ready returns the cycle after the result beat. Reset
// (rst_n low, synchronous) idles the sequencer and loads the year window with
// 1582..2024.
`default_nettype none

// Top level: configuration registers plus the iterative date core.
// Depends on gdsd_pkg, gdsd_regs and gdsd_core.
module gregorian_date_subtract_days #(
  parameter int DAYS_WIDTH = 16,
  parameter int YEAR_WIDTH = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [4:0]            in_day,
  input  wire logic [3:0]            in_month,
  input  wire logic [YEAR_WIDTH-1:0] in_year,
  input  wire logic [DAYS_WIDTH-1:0] in_days_back,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [2:0]            out_status,
  output logic      [4:0]            out_result_day,
  output logic      [3:0]            out_result_month,
  output logic      [YEAR_WIDTH-1:0] out_result_year
);
  import gdsd_pkg::*;

  logic [YEAR_WIDTH-1:0] min_year;
  logic [YEAR_WIDTH-1:0] max_year;

  // Year window; the user must write it only while the core is idle (not enforced here).
  gdsd_regs #(
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .min_year (min_year),
    .max_year (max_year)
  );

  // Capture the beat, reduce the year mod 400 for the leap rule, check the
  // date in year/month/day order, then borrow month by month and hold the
  // result until the downstream side takes it.
  gdsd_core #(
    .DAYS_WIDTH (DAYS_WIDTH),
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .min_year         (min_year),
    .max_year         (max_year),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_day           (in_day),
    .in_month         (in_month),
    .in_year          (in_year),
    .in_days_back     (in_days_back),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_result_day   (out_result_day),
    .out_result_month (out_result_month),
    .out_result_year  (out_result_year)
  );

endmodule

`default_nettype wire

### bench/gregorian_date_subtract_days_test.sv
// Self-checking bench for gregorian_date_subtract_days: directed and random date
// requests over several year windows, results checked against a built-in calendar.
// Depends on gdsd_pkg and the block's RTL.
`timescale 1ns / 100ps

import gdsd_pkg::*;

typedef struct packed {
  logic [2:0]  status;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [11:0] year;
} date_result_t;

// Holds the window copy, predicts each request and checks results in order.
class date_scoreboard;
  int           min_yr;
  int           max_yr;
  date_result_t expected_q[$];
  int           errors;
  int           requests;
  int           by_status[5];

  function new();
    min_yr = MIN_YEAR_RST;
    max_yr = MAX_YEAR_RST;
  endfunction

  static function int month_days(int m, int y);
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m == MONTH_FEB) begin
      if ((y % 4 == 0 && y % CENTURY != 0) || y % QUAD_CENTURY == 0) return 29;
      return 28;
    end
    return 31;
  endfunction

  function date_result_t earlier_date(logic [4:0] d_in, logic [3:0] m_in,
                                      logic [11:0] y_in, logic [15:0] b_in);
    int d;
    int m;
    int y;
    date_result_t r;
    d = d_in;
    m = m_in;
    y = y_in;
    r = '0;
    r.status = STS_OK;
    if (y < min_yr || y > max_yr) r.status = STS_BAD_YEAR;
    else if (m < MONTH_JAN || m > MONTH_DEC) r.status = STS_BAD_MONTH;
    else if (d < 1 || d > month_days(m, y)) r.status = STS_BAD_DAY;
    if (r.status == STS_OK) begin
      d -= int'(b_in);
      // borrow the length of the month stepped into
      while (d < 1) begin
        m--;
        if (m < MONTH_JAN) begin
          m = MONTH_DEC;
          y--;
        end
        if (y < min_yr) begin
          r.status = STS_UNDERFLOW;
          break;
        end
        d += month_days(m, y);
      end
    end
    if (r.status == STS_OK) begin
      r.day   = d[4:0];
      r.month = m[3:0];
      r.year  = y[11:0];
    end
    return r;
  endfunction

  function void note_request(logic [4:0] d, logic [3:0] m, logic [11:0] y,
                             logic [15:0] b);
    expected_q.push_back(earlier_date(d, m, y, b));
    requests++;
  endfunction

  function void check_answer(date_result_t got);
    date_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result with nothing pending: status %0d %0d/%0d/%0d", $time,
               got.status, got.day, got.month, got.year);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.status <= STS_UNDERFLOW) by_status[got.status]++;
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      errors++;
    end
    if (got.day !== want.day) begin
      $display("%0t: day expected %0d actual %0d", $time, want.day, got.day);
      errors++;
    end
    if (got.month !== want.month) begin
      $display("%0t: month expected %0d actual %0d", $time, want.month, got.month);
      errors++;
    end
    if (got.year !== want.year) begin
      $display("%0t: year expected %0d actual %0d", $time, want.year, got.year);
      errors++;
    end
  endfunction
endclass

module gregorian_date_subtract_days_test;
  localparam int YW = 12;
  localparam int DW = 16;
  // Longest quiet stretch: a full 16-bit borrow on top of the long receiver
  // hold, with a wide margin.
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic          clk = 0;
  logic          rst_n = 0;
  logic          psel = 0;
  logic          penable = 0;
  logic          pwrite = 0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid = 0;
  logic          in_ready;
  logic [4:0]    in_day = '0;
  logic [3:0]    in_month = '0;
  logic [YW-1:0] in_year = '0;
  logic [DW-1:0] in_days_back = '0;
  logic          out_valid;
  logic          out_ready;
  logic [2:0]    out_status;
  logic [4:0]    out_result_day;
  logic [3:0]    out_result_month;
  logic [YW-1:0] out_result_year;

  date_scoreboard sb = new();
  bit  calm = 0;       // both sides run without idling while set
  int  rx_beats = 0;
  int  quiet = 0;
  int  windows = 1;

  gregorian_date_subtract_days #(.DAYS_WIDTH(DW), .YEAR_WIDTH(YW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_day(in_day), .in_month(in_month),
    .in_year(in_year), .in_days_back(in_days_back),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_result_day(out_result_day), .out_result_month(out_result_month),
    .out_result_year(out_result_year)
  );

  always #10 clk = ~clk;

  // Sample both channels at the rising edge; note requests, check results and
  // count quiet cycles for the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (in_valid && in_ready) begin
        sb.note_request(in_day, in_month, in_year, in_days_back);
      end
      if (out_valid && out_ready) begin
        sb.check_answer('{out_status, out_result_day, out_result_month, out_result_year});
        rx_beats <= rx_beats + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results pending", $time, quiet,
                 sb.expected_q.size());
        $display("gregorian_date_subtract_days_test NOT OK");
        $finish;
      end
    end
  end

  // Result side: stall about one cycle in ten, except in the calm stretch;
  // once, hold off for a long stretch so the block backs up its input.
  initial begin
    bit held;
    held = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (!held && rx_beats == 60) begin
        held = 1;
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // Offer one request; idle first at random, then hold valid until accepted.
  task automatic send_date(input logic [4:0] d, input logic [3:0] m,
                           input logic [YW-1:0] y, input logic [DW-1:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_day       <= d;
    in_month     <= m;
    in_year      <= y;
    in_days_back <= b;
    in_valid     <= 1;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  // Write a register (setup + access), then read it back.
  task automatic cfg_write(input logic reg_idx, input int value);
    @(negedge clk);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    @(negedge clk);
    penable <= 0;
    pwrite  <= 0;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    if (prdata !== 32'(value)) begin
      $display("%0t: register %0d read expected %0d actual %0d", $time, reg_idx,
               value, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 0;
    penable <= 0;
  endtask

  // Change the year window only with the block idle.
  task automatic set_window(input int lo, input int hi);
    wait_drained();
    repeat (15) @(negedge clk);
    cfg_write(REG_MIN_YEAR, lo);
    cfg_write(REG_MAX_YEAR, hi);
    sb.min_yr = lo;
    sb.max_yr = hi;
    windows++;
  endtask

  // Mostly valid dates inside the window (often at its edges), some near misses
  // and some raw noise; days to subtract are mostly small, a few full-width.
  task automatic run_random(input int count);
    logic [4:0]    d;
    logic [3:0]    m;
    logic [YW-1:0] y;
    logic [DW-1:0] b;
    int            pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (sb.min_yr <= sb.max_yr) begin
        case ($urandom_range(0, 4))
          0:       y = YW'(sb.min_yr);
          1:       y = YW'(sb.max_yr);
          default: y = YW'($urandom_range(sb.max_yr, sb.min_yr));
        endcase
      end else begin
        y = YW'($urandom);
      end
      m = 4'($urandom_range(MONTH_DEC, MONTH_JAN));
      if (pick < 78) begin
        d = 5'($urandom_range(sb.month_days(m, y), 1));
      end else if (pick < 90) begin
        // near miss: one past the month end, day zero, or a month out of range
        case ($urandom_range(0, 2))
          0:       d = 5'(sb.month_days(m, y) + 1);
          1:       d = 0;
          default: begin
            d = 5'($urandom_range(28, 1));
            m = 4'($urandom_range(15, 13) & ((pick & 1) ? 4'hf : 4'h0));
          end
        endcase
      end else begin
        d = 5'($urandom);
        m = 4'($urandom);
        y = YW'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60)      b = DW'($urandom_range(40, 0));
      else if (pick < 85) b = DW'($urandom_range(1000, 0));
      else if (pick < 95) b = DW'($urandom_range(8000, 0));
      else                b = DW'($urandom);
      send_date(d, m, y, b);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1;

    // Directed under the reset window 1582..2024.
    send_date(1, 1, 1582, 0);        // zero days at the window floor
    send_date(31, 12, 2024, 0);      // zero days at the window ceiling
    send_date(29, 2, 2000, 0);       // leap by the 400 rule
    send_date(29, 2, 1900, 0);       // century, not leap: bad day
    send_date(29, 2, 2024, 7);       // leap by the 4 rule
    send_date(29, 2, 2023, 0);       // bad day
    send_date(0, 5, 2000, 1);        // day zero
    send_date(31, 4, 2000, 1);       // day past a 30-day month
    send_date(31, 1, 2000, 31);
    send_date(10, 0, 2000, 1);       // month zero
    send_date(10, 13, 2000, 1);
    send_date(10, 15, 2000, 1);
    send_date(10, 6, 1581, 1);       // year below window
    send_date(10, 6, 2025, 1);       // year above window
    send_date(0, 15, 4095, 65535);   // all fields bad: year check wins
    send_date(0, 0, 0, 0);
    send_date(1, 3, 2000, 1);        // borrow into leap February
    send_date(1, 3, 1900, 1);        // borrow into common February
    send_date(1, 1, 2000, 1);        // borrow across the year
    send_date(15, 10, 1582, 65535);  // falls below the window
    send_date(1, 1, 1582, 1);
    send_date(31, 12, 2024, 65535);
    run_random(120);
    // sender pause until the block has fully drained
    wait_drained();
    calm = 1;
    run_random(100);
    calm = 0;
    run_random(30);

    // Full range: stepping back from year zero underflows.
    set_window(0, 4095);
    send_date(1, 1, 0, 1);
    send_date(15, 6, 4095, 65535);
    run_random(200);

    // Single-year window: underflow is common.
    set_window(2000, 2000);
    run_random(150);

    // Inverted window: every year rejected.
    set_window(3000, 100);
    send_date(1, 1, 2000, 5);
    run_random(50);

    set_window(4095, 4095);
    send_date(31, 12, 4095, 365);
    run_random(100);

    set_window(1, 3000);
    run_random(150);

    wait_drained();
    repeat (30) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
      sb.errors++;
    end
    $display("Covered %0d requests over %0d year windows, %0d mismatches.",
             sb.requests, windows, sb.errors);
    $display("Results by status: ok %0d, year %0d, month %0d, day %0d, underflow %0d.",
             sb.by_status[0], sb.by_status[1], sb.by_status[2], sb.by_status[3],
             sb.by_status[4]);
    if (sb.errors == 0) begin
      $display("gregorian_date_subtract_days_test OK");
    end else begin
      $display("gregorian_date_subtract_days_test NOT OK");
    end
    $finish;
  end
endmodule

### files.f
sv/gdsd_pkg.sv
sv/gdsd_regs.sv
sv/gdsd_core.sv
sv/gregorian_date_subtract_days.sv
bench/gregorian_date_subtract_days_test.sv
